### rtl/core/mgm_pkg.sv
package mgm_pkg;

  localparam int FRAC_BITS      = 28;
  localparam int MAX_HALF_STEPS = 255;
  localparam int QDEPTH         = 2;
  localparam int QPTR_W         = $clog2(QDEPTH);
  localparam int QCNT_W         = $clog2(QDEPTH + 1);

  // escape when zr^2 + zi^2 > 4.0 in 2*FRAC_BITS fraction bits
  localparam logic [63:0] ESC_BOUND = 64'd1 << ((2 * FRAC_BITS + 2) % 64);

  typedef logic signed [31:0] fix_t;

  typedef enum logic [2:0] {
    REG_CENTER_REAL     = 3'd0,
    REG_CENTER_IMAG     = 3'd1,
    REG_IMAG_STEP       = 3'd2,
    REG_REAL_STEP       = 3'd3,
    REG_REAL_HALF_STEPS = 3'd4,
    REG_IMAG_HALF_STEPS = 3'd5,
    REG_ITER_LIMIT      = 3'd6
  } reg_idx_t;

  typedef struct packed {
    fix_t        center_real;
    fix_t        center_imag;
    logic [27:0] imag_step;
    logic [27:0] real_step;
    logic [7:0]  real_half_steps;
    logic [7:0]  imag_half_steps;
    logic [15:0] iteration_limit;
  } cfg_t;

  typedef struct packed {
    logic off_grid;
    fix_t cr;
    fix_t ci;
  } job_t;

  function automatic fix_t sat32(input logic signed [63:0] v);
    fix_t r;
    if (v > 64'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic [7:0] clamp_half(input logic [7:0] h);
    logic [7:0] r;
    if (int'(h) > MAX_HALF_STEPS) begin
      r = 8'(MAX_HALF_STEPS);
    end else begin
      r = h;
    end
    return r;
  endfunction

endpackage

### rtl/core/mandelbrot_grid_membership_core.sv
// Escape-time Mandelbrot membership test for one grid position per request.
// A front stage checks the position against the grid and forms c in its
// capture, multiply and push states; a 2-entry queue feeds the iteration
// engine, which runs each iteration of z = z*z + c as a multiply state (the
// three 32x32 multipliers) followed by an update state (the add, saturate
// and escape compare). Off-grid positions skip the iterations entirely.
// Configuration writes are always accepted and must be made only while no
// request is in flight.
module mandelbrot_grid_membership_core
  import mgm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [8:0] row_index, [17:9] column_index
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [0] in_set
  output logic        out_tuser   // [0] out_of_grid
);

  cfg_t cfg_r;
  logic q_wr_valid, q_wr_ready, q_rd_valid, q_rd_ready;
  job_t q_wr_data, q_rd_data;
  logic in_set;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.center_real     <= '0;
      cfg_r.center_imag     <= '0;
      cfg_r.imag_step       <= 28'd2684355;
      cfg_r.real_step       <= 28'd2684355;
      cfg_r.real_half_steps <= 8'd20;
      cfg_r.imag_half_steps <= 8'd20;
      cfg_r.iteration_limit <= 16'd100;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_CENTER_REAL:     cfg_r.center_real     <= cfg_data;
        REG_CENTER_IMAG:     cfg_r.center_imag     <= cfg_data;
        REG_IMAG_STEP:       cfg_r.imag_step       <= cfg_data[27:0];
        REG_REAL_STEP:       cfg_r.real_step       <= cfg_data[27:0];
        REG_REAL_HALF_STEPS: cfg_r.real_half_steps <= cfg_data[7:0];
        REG_IMAG_HALF_STEPS: cfg_r.imag_half_steps <= cfg_data[7:0];
        REG_ITER_LIMIT:      cfg_r.iteration_limit <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  mgm_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .row_index    (in_tdata[8:0]),
    .column_index (in_tdata[17:9]),
    .q_wr_valid   (q_wr_valid),
    .q_wr_ready   (q_wr_ready),
    .q_wr_data    (q_wr_data)
  );

  mgm_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (q_wr_valid),
    .wr_ready (q_wr_ready),
    .wr_data  (q_wr_data),
    .rd_valid (q_rd_valid),
    .rd_ready (q_rd_ready),
    .rd_data  (q_rd_data)
  );

  mgm_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .q_rd_valid  (q_rd_valid),
    .q_rd_ready  (q_rd_ready),
    .q_rd_data   (q_rd_data),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_in_set  (in_set),
    .out_of_grid (out_tuser)
  );

  assign out_tdata = {7'b0, in_set};

endmodule

### rtl/core/mgm_front.sv
module mgm_front
  import mgm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [8:0] row_index,
  input  logic [8:0] column_index,
  output logic       q_wr_valid,
  input  logic       q_wr_ready,
  output job_t       q_wr_data
);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_MUL  = 3'b010,
    F_PUSH = 3'b100
  } fstate_t;

  fstate_t            state_r, state_nxt;
  logic               off_r;
  logic signed [9:0]  dr_r, di_r;
  logic signed [38:0] pr_r, pi_r;
  logic [7:0]         hr, hi;

  assign hr = clamp_half(cfg.real_half_steps);
  assign hi = clamp_half(cfg.imag_half_steps);

  assign in_ready   = (state_r == F_IDLE);
  assign q_wr_valid = (state_r == F_PUSH);

  always_comb begin
    q_wr_data.off_grid = off_r;
    q_wr_data.cr       = sat32(64'(cfg.center_real) + 64'(pr_r));
    q_wr_data.ci       = sat32(64'(cfg.center_imag) + 64'(pi_r));
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: begin
        if (in_valid) state_nxt = F_MUL;
      end
      F_MUL:  state_nxt = F_PUSH;
      F_PUSH: begin
        if (q_wr_ready) state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == F_IDLE && in_valid) begin
      off_r <= (row_index > {hi, 1'b0}) || (column_index > {hr, 1'b0});
      dr_r  <= $signed({1'b0, column_index}) - $signed({2'b00, hr});
      di_r  <= $signed({2'b00, hi}) - $signed({1'b0, row_index});
    end
    if (state_r == F_MUL) begin
      pr_r <= dr_r * $signed({1'b0, cfg.real_step});
      pi_r <= di_r * $signed({1'b0, cfg.imag_step});
    end
  end

endmodule

### rtl/core/mgm_queue.sv
module mgm_queue
  import mgm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_ready,
  input  job_t wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output job_t rd_data
);

  job_t              q_mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              push, pop;

  assign wr_ready = (int'(count_r) < QDEPTH);
  assign rd_valid = (count_r != '0);
  assign rd_data  = q_mem[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) q_mem[wr_ptr_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (int'(wr_ptr_r) == QDEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (int'(rd_ptr_r) == QDEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(count_r) <= QDEPTH)
    else $error("queue count above depth");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> int'(count_r) == int'($past(count_r)) + 1)
    else $error("queue count did not grow on push");

endmodule

### rtl/core/mgm_back.sv
module mgm_back
  import mgm_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  cfg_t cfg,
  input  logic q_rd_valid,
  output logic q_rd_ready,
  input  job_t q_rd_data,
  output logic out_valid,
  input  logic out_ready,
  output logic out_in_set,
  output logic out_of_grid
);

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_MUL  = 4'b0010,
    B_UPD  = 4'b0100,
    B_DONE = 4'b1000
  } bstate_t;

  bstate_t            state_r, state_nxt;
  fix_t               cr_r, ci_r, zr_r, zi_r;
  logic signed [63:0] sqr_r, sqi_r, cross_r;
  logic [15:0]        iter_r;
  logic               res_in_set_r, res_off_r;
  logic               out_valid_r, out_in_set_r, out_off_r;
  logic [63:0]        mag;
  logic               escaped, at_limit, out_load;
  logic signed [63:0] diff;

  assign mag      = $unsigned(sqr_r) + $unsigned(sqi_r);
  assign diff     = sqr_r - sqi_r;
  assign escaped  = (iter_r != '0) && (mag > ESC_BOUND);
  assign at_limit = (iter_r == cfg.iteration_limit);
  assign out_load = (state_r == B_DONE) && (!out_valid_r || out_ready);

  assign q_rd_ready  = (state_r == B_IDLE);
  assign out_valid   = out_valid_r;
  assign out_in_set  = out_in_set_r;
  assign out_of_grid = out_off_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (q_rd_valid) state_nxt = q_rd_data.off_grid ? B_DONE : B_MUL;
      end
      B_MUL: state_nxt = B_UPD;
      B_UPD: state_nxt = (escaped || at_limit) ? B_DONE : B_MUL;
      B_DONE: begin
        if (out_load) state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      B_IDLE: begin
        if (q_rd_valid) begin
          cr_r         <= q_rd_data.cr;
          ci_r         <= q_rd_data.ci;
          zr_r         <= '0;
          zi_r         <= '0;
          iter_r       <= '0;
          res_in_set_r <= 1'b0;
          res_off_r    <= q_rd_data.off_grid;
        end
      end
      B_MUL: begin
        sqr_r   <= zr_r * zr_r;
        sqi_r   <= zi_r * zi_r;
        cross_r <= zr_r * zi_r;
      end
      B_UPD: begin
        if (escaped) begin
          res_in_set_r <= 1'b0;
        end else if (at_limit) begin
          res_in_set_r <= 1'b1;
        end else begin
          zr_r   <= sat32((diff >>> FRAC_BITS) + 64'(cr_r));
          zi_r   <= sat32((cross_r >>> (FRAC_BITS - 1)) + 64'(ci_r));
          iter_r <= iter_r + 1'b1;
        end
      end
      B_DONE: begin
        if (out_load) begin
          out_in_set_r <= res_in_set_r;
          out_off_r    <= res_off_r;
        end
      end
      default: ;
    endcase
  end

  a_iter_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == B_UPD) |-> (iter_r <= cfg.iteration_limit))
    else $error("iteration count passed limit");

  a_off_not_in_set: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_off_r) |-> !out_in_set_r)
    else $error("off-grid point reported in set");

endmodule
